// ===== rtl/srb_pkg.sv =====
// shared types and constants of the segment reorder buffer
package srb_pkg;

	localparam int unsigned DEF_ENTRIES = 16;
	localparam int unsigned SEQ_W = 32;
	localparam int unsigned LEN_W = 10;
	localparam int unsigned TAG_W = 8;
	localparam int unsigned OFS_W = 14;
	localparam logic [SEQ_W-1:0] ACK_RESET = 32'd1;

	typedef struct packed {
		logic [SEQ_W-1:0] seq;
		logic [LEN_W-1:0] len;
		logic [TAG_W-1:0] tag;
	} entry_t;

	typedef struct packed {
		logic ins;
		logic shl;
	} store_cmd_t;

endpackage

// ===== rtl/srb_store.sv =====
// sorted entry store: shift-insert, shift-down by one, one read port
module srb_store #(
	parameter int unsigned ENTRIES = srb_pkg::DEF_ENTRIES,
	localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic               clk,
	input  srb_pkg::store_cmd_t cmd,
	input  logic [IW-1:0]      pos,
	input  srb_pkg::entry_t    wr_data,
	input  logic [IW-1:0]      rd_idx,
	output srb_pkg::entry_t    rd_data
);

	srb_pkg::entry_t mem_q [ENTRIES];

	assign rd_data = mem_q[rd_idx];

	always_ff @(posedge clk) begin
		for (int j = 0; j < ENTRIES; j++) begin
			if (cmd.ins) begin
				if (IW'(j) == pos) begin
					mem_q[j] <= wr_data;
				end else if (j > 0 && IW'(j) > pos) begin
					mem_q[j] <= mem_q[j-1];
				end
			end else if (cmd.shl && j + 1 < ENTRIES) begin
				mem_q[j] <= mem_q[j+1];
			end
		end
	end

endmodule

// ===== rtl/segment_reorder_buffer.sv =====
// top level of the segment reorder buffer: sequencer, ack register, result register
// Each item (start high while busy low) is handled one at a time by a small
// sequencer around a single shift-sorted entry store with one read port. While
// busy is high it runs the position scan, the insert, the ack match scan, the
// run walk, one pass over the entries up to the run end to emit the run, one
// more to shift them out, then the ack. With no match it runs the position scan,
// the insert, the ack match scan and the ack. A corrupt item holds busy for one
// cycle. Each result is on the result ports for exactly one cycle, marked by
// out_valid; the receiver cannot stall them, and every item ends with an ack
// result (last high). The ack result shows in the cycle after busy falls, when
// the next item can already be taken. A configuration write is taken only while
// idle and loads the expected sequence number at once.
module segment_reorder_buffer #(
	parameter int unsigned BUFFER_ENTRIES = srb_pkg::DEF_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] seq_num,
	input  logic [9:0]  seg_len,
	input  logic [7:0]  payload_tag,
	input  logic        corrupt,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output logic        out_valid,
	output logic        kind,
	output logic [7:0]  out_tag,
	output logic [9:0]  out_len,
	output logic [13:0] out_offset,
	output logic [31:0] ack_num,
	output logic        overflow,
	output logic        last
);

	localparam int unsigned IW = (BUFFER_ENTRIES > 1) ? $clog2(BUFFER_ENTRIES) : 1;
	localparam int unsigned CW = $clog2(BUFFER_ENTRIES + 1);
	localparam logic [CW-1:0] FULL = CW'(BUFFER_ENTRIES);

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_POS   = 3'd1;
	localparam logic [2:0] ST_INS   = 3'd2;
	localparam logic [2:0] ST_FIND  = 3'd3;
	localparam logic [2:0] ST_WALK  = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;
	localparam logic [2:0] ST_SHIFT = 3'd6;
	localparam logic [2:0] ST_ACK   = 3'd7;

	logic [2:0]      state_q;
	logic [CW-1:0]   fill_q;
	logic [CW-1:0]   ptr_q;
	logic [CW-1:0]   run_end_q;   // exclusive end of the contiguous run
	logic [31:0]     ack_q;
	logic [31:0]     exp_q;       // sequence expected next in the run
	logic [13:0]     ofs_q;
	logic            ovf_q;
	srb_pkg::entry_t item_q;

	// the run start is remembered so earlier entries are not emitted
	logic [CW-1:0]   run_start_q;
	logic            run_start_ok;

	srb_pkg::store_cmd_t cmd;
	srb_pkg::entry_t     rd;
	logic                in_range;

	srb_store #(.ENTRIES(BUFFER_ENTRIES)) u_store (
		.clk     (clk),
		.cmd     (cmd),
		.pos     (ptr_q[IW-1:0]),
		.wr_data (item_q),
		.rd_idx  (ptr_q[IW-1:0]),
		.rd_data (rd)
	);

	assign busy         = (state_q != ST_IDLE);
	// configuration lands only between items
	assign cfg_ready    = (state_q == ST_IDLE);
	assign in_range     = (ptr_q < fill_q);
	assign run_start_ok = (ptr_q >= run_start_q);

	always_comb begin
		cmd.ins = (state_q == ST_INS);
		cmd.shl = (state_q == ST_SHIFT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			ptr_q     <= '0;
			run_end_q <= '0;
			ack_q     <= srb_pkg::ACK_RESET;
			exp_q     <= '0;
			ovf_q     <= 1'b0;
			item_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			// one strobe per delivered run entry, one for the closing ack
			out_valid <= (state_q == ST_ACK) || (state_q == ST_EMIT && run_start_ok);
			case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						ack_q <= cfg_data;
					end
					if (start) begin
						item_q <= '{seq: seq_num, len: seg_len, tag: payload_tag};
						ptr_q  <= '0;
						ovf_q  <= 1'b0;
						if (corrupt) begin
							state_q <= ST_ACK;
						end else begin
							// full buffer: the top entry falls off
							if (fill_q == FULL) begin
								fill_q <= FULL - CW'(1);
								ovf_q  <= 1'b1;
							end
							state_q <= ST_POS;
						end
					end
				end
				ST_POS: begin
					if (in_range && !(item_q.seq < rd.seq)) begin
						ptr_q <= ptr_q + CW'(1);
					end else begin
						state_q <= ST_INS;
					end
				end
				ST_INS: begin
					fill_q  <= fill_q + CW'(1);
					ptr_q   <= '0;
					state_q <= ST_FIND;
				end
				ST_FIND: begin
					if (!in_range) begin
						state_q <= ST_ACK;
					end else if (rd.seq == ack_q) begin
						exp_q   <= rd.seq + 32'(rd.len);
						ptr_q   <= ptr_q + CW'(1);
						state_q <= ST_WALK;
					end else begin
						ptr_q <= ptr_q + CW'(1);
					end
				end
				ST_WALK: begin
					if (in_range && rd.seq == exp_q) begin
						exp_q <= rd.seq + 32'(rd.len);
						ptr_q <= ptr_q + CW'(1);
					end else begin
						// run start plus total length equals exp_q
						ack_q     <= exp_q;
						run_end_q <= ptr_q;
						ptr_q     <= '0;
						state_q   <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// entries before the run are skipped, then the run goes out
					ptr_q <= ptr_q + CW'(1);
					if (ptr_q + CW'(1) == run_end_q) begin
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					fill_q <= fill_q - CW'(1);
					ptr_q  <= ptr_q - CW'(1);
					if (ptr_q == CW'(1)) begin
						state_q <= ST_ACK;
					end
				end
				ST_ACK: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIND && in_range && rd.seq == ack_q) begin
			run_start_q <= ptr_q;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT) begin
			if (run_start_ok) begin
				ofs_q <= ofs_q + 14'(rd.len);
			end
			kind       <= 1'b0;
			out_tag    <= rd.tag;
			out_len    <= rd.len;
			out_offset <= ofs_q;
			last       <= 1'b0;
		end else begin
			ofs_q      <= '0;
			kind       <= 1'b1;
			out_tag    <= '0;
			out_len    <= '0;
			out_offset <= '0;
			last       <= 1'b1;
		end
		overflow <= ovf_q;
		ack_num  <= ack_q;
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL) else $error("fill count above depth");
	a_ack_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind |-> last) else $error("ack without last");
	a_ack_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> !busy) else $error("ack while still busy");

endmodule

// ===== test/tb_segment_reorder_buffer.sv =====
// testbench of the segment reorder buffer: sorted insertion, in-order delivery, acks
`timescale 1ns / 1ps

module tb_segment_reorder_buffer;

	localparam int DEPTH = 16;
	localparam int LIMIT = 5000;

	typedef struct {
		logic [31:0] seq;
		logic [9:0]  len;
		logic [7:0]  tag;
		logic        bad;
		logic        is_cfg;
	} seg_t;

	typedef struct {
		logic        kind;
		logic [7:0]  tag;
		logic [9:0]  len;
		logic [13:0] ofs;
		logic [31:0] ack;
		logic        ovf;
		logic        last;
	} res_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic        busy;
	logic [31:0] seq_num = '0;
	logic [9:0]  seg_len = '0;
	logic [7:0]  payload_tag = '0;
	logic        corrupt = 0;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;
	logic        out_valid;
	logic        kind;
	logic [7:0]  out_tag;
	logic [9:0]  out_len;
	logic [13:0] out_offset;
	logic [31:0] ack_num;
	logic        overflow;
	logic        last;

	segment_reorder_buffer dut (.*);

	always #2 clk = ~clk;

	seg_t pending[$];
	res_t expected_results[$];
	logic [31:0] buf_seq[DEPTH];
	logic [9:0]  buf_len[DEPTH];
	logic [7:0]  buf_tag[DEPTH];
	int          buf_fill = 0;
	logic [31:0] model_ack = 32'd1;
	int          errors = 0;
	int          idle_cycles = 0;
	bit          calm = 0;
	bit          in_flight = 0;
	bit          took_item = 0, took_cfg = 0;

	// work out the results of one accepted segment and update the shadow buffer
	task automatic reassemble(input seg_t s);
		int pos, hit, tail, drop;
		bit ovf;
		logic [13:0] ofs;
		res_t r;
		ovf = 0;
		if (!s.bad) begin
			// full: drop the top entry before inserting
			if (buf_fill >= DEPTH) begin
				buf_fill = DEPTH - 1;
				ovf = 1;
			end
			pos = buf_fill;
			for (int i = 0; i < buf_fill; i++)
				if (s.seq < buf_seq[i]) begin
					pos = i;
					break;
				end
			for (int j = buf_fill; j > pos; j--) begin
				buf_seq[j] = buf_seq[j-1];
				buf_len[j] = buf_len[j-1];
				buf_tag[j] = buf_tag[j-1];
			end
			buf_seq[pos] = s.seq;
			buf_len[pos] = s.len;
			buf_tag[pos] = s.tag;
			buf_fill++;
			hit = -1;
			for (int i = 0; i < buf_fill; i++)
				if (buf_seq[i] == model_ack) begin
					hit = i;
					break;
				end
			if (hit >= 0) begin
				tail = hit;
				while (tail + 1 < buf_fill
						&& buf_seq[tail] + 32'(buf_len[tail]) == buf_seq[tail+1])
					tail++;
				for (int i = hit; i <= tail; i++)
					model_ack += 32'(buf_len[i]);
				ofs = '0;
				for (int i = hit; i <= tail; i++) begin
					r = '{1'b0, buf_tag[i], buf_len[i], ofs, model_ack, ovf, 1'b0};
					expected_results.push_back(r);
					ofs += 14'(buf_len[i]);
				end
				// entries ahead of the run leave with it
				drop = tail + 1;
				for (int i = 0; i + drop < buf_fill; i++) begin
					buf_seq[i] = buf_seq[i+drop];
					buf_len[i] = buf_len[i+drop];
					buf_tag[i] = buf_tag[i+drop];
				end
				buf_fill -= drop;
			end
		end
		r = '{1'b1, 8'h0, 10'h0, 14'h0, model_ack, ovf, 1'b1};
		expected_results.push_back(r);
	endtask

	// driver: one item at a time, config only once everything drained
	always @(negedge clk) begin
		if (arst_n) begin
			// a stretch in the middle of the run goes without idling
			calm = (pending.size() > 60 && pending.size() <= 110);
			if (!start && !cfg_valid && !in_flight && pending.size() > 0
					&& (calm || $urandom_range(99) >= 24)) begin
				if (pending[0].is_cfg) begin
					if (expected_results.size() == 0) begin
						cfg_data <= pending[0].seq;
						cfg_valid <= 1;
					end
				end else begin
					seq_num <= pending[0].seq;
					seg_len <= pending[0].len;
					payload_tag <= pending[0].tag;
					corrupt <= pending[0].bad;
					start <= 1;
				end
			end else if (start && took_item) begin
				start <= 0;
			end else if (cfg_valid && took_cfg) begin
				cfg_valid <= 0;
			end
		end
	end

	// monitor: acceptance and result checking at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			took_item = 0;
			took_cfg = 0;
			idle_cycles++;
			if (start && !busy) begin
				reassemble(pending.pop_front());
				took_item = 1;
				in_flight = 1;
				idle_cycles = 0;
			end
			if (cfg_valid && cfg_ready) begin
				model_ack = cfg_data;
				void'(pending.pop_front());
				took_cfg = 1;
				idle_cycles = 0;
			end
			if (out_valid) begin
				idle_cycles = 0;
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result kind=%0d ack=%h", kind, ack_num);
				end else begin
					res_t e;
					e = expected_results.pop_front();
					if (e.kind !== kind || e.tag !== out_tag || e.len !== out_len
							|| e.ofs !== out_offset || e.ack !== ack_num
							|| e.ovf !== overflow || e.last !== last) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch exp k%0d t%h l%0d o%0d a%h v%0d e%0d",
								e.kind, e.tag, e.len, e.ofs, e.ack, e.ovf, e.last);
							$display("         got k%0d t%h l%0d o%0d a%h v%0d e%0d",
								kind, out_tag, out_len, out_offset, ack_num, overflow, last);
						end
					end
					if (last)
						in_flight = 0;
				end
			end
			if (idle_cycles >= LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	function automatic seg_t mk(logic [31:0] s, logic [9:0] l, logic [7:0] t, logic b);
		seg_t x;
		x = '{s, l, t, b, 1'b0};
		return x;
	endfunction

	function automatic seg_t mk_cfg(logic [31:0] v);
		seg_t x;
		x = '{v, 10'h0, 8'h0, 1'b0, 1'b1};
		return x;
	endfunction

	initial begin
		logic [31:0] base, nxt;
		int n;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1;
		// directed: out of order, duplicates, corrupt, extremes, overflow, wrap
		pending.push_back(mk(32'd11, 10'd5, 8'hff, 1'b0));
		pending.push_back(mk(32'd1, 10'd10, 8'h01, 1'b1));
		pending.push_back(mk(32'd1, 10'd10, 8'h01, 1'b0));
		pending.push_back(mk(32'd16, 10'd1023, 8'h00, 1'b0));
		pending.push_back(mk(32'hffffffff, 10'd0, 8'haa, 1'b0));
		for (int i = 0; i < 17; i++)
			pending.push_back(mk(32'd5000 + 32'(i), 10'(i), 8'(i), 1'b0));
		pending.push_back(mk_cfg(32'hfffffffe));
		pending.push_back(mk(32'hfffffffe, 10'd4, 8'h55, 1'b0));
		pending.push_back(mk_cfg(32'h0));
		pending.push_back(mk(32'h0, 10'd0, 8'h77, 1'b0));
		// random: mostly contiguous runs shuffled, some noise
		base = 32'h0;
		while (pending.size() < 175) begin
			if ($urandom_range(9) == 0) begin
				base = $urandom;
				pending.push_back(mk_cfg(base));
			end
			n = $urandom_range(1, 6);
			begin
				seg_t run[$];
				run.delete();
				nxt = base;
				for (int i = 0; i < n; i++) begin
					run.push_back(mk(nxt, 10'($urandom_range(1023)), 8'($urandom), 1'b0));
					nxt += 32'(run[i].len);
				end
				run.shuffle();
				foreach (run[i]) begin
					if ($urandom_range(9) == 0)
						pending.push_back(mk($urandom, 10'($urandom), 8'($urandom), 1'b1));
					if ($urandom_range(9) == 0)
						pending.push_back(mk($urandom, 10'($urandom), 8'($urandom), 1'b0));
					pending.push_back(run[i]);
				end
				base = nxt;
			end
		end
		pending.push_back(mk_cfg(32'h1));
		pending.push_back(mk(32'h1, 10'd3, 8'h3c, 1'b0));
		while (pending.size() != 0 || expected_results.size() != 0 || in_flight)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/srb_pkg.sv
rtl/srb_store.sv
rtl/segment_reorder_buffer.sv
test/tb_segment_reorder_buffer.sv
